[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL files of the date query block.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_HOLDS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define ASSERT_LATER(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_LATER(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/cdq_pkg.sv]
// Types, constants and calendar tables for the date query pipeline.
// Depends on nothing; used by every module of the block.
package cdq_pkg;

	localparam int YEAR_W   = 14;
	localparam int SHIFT_W  = 15;
	localparam int QUO_W    = 8;
	localparam int SUM_W    = 15;
	localparam int Q7_W     = 12;

	localparam logic [SHIFT_W-1:0] YEAR_OFFSET = 15'd400;
	localparam logic [14:0] DIV100_MUL = 15'd20972;
	localparam int DIV100_SHIFT = 21;
	localparam logic [14:0] DIV7_MUL = 15'd18725;
	localparam int DIV7_SHIFT = 17;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} query_t;

	typedef struct packed {
		logic [2:0] weekday;
		logic       leap_year;
		logic [4:0] month_length;
		logic       end_of_week;
		logic       weekend;
		logic       business_day;
		logic [2:0] days_to_week_end;
		logic [4:0] days_to_month_end;
		logic [8:0] days_to_year_end;
		logic       date_valid;
	} result_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic [SHIFT_W-1:0] yy;
		logic [3:0]         mm;
		logic [QUO_W-1:0]   qy;
		logic [QUO_W-1:0]   qyy;
	} div_t;

	typedef struct packed {
		logic             leap;
		logic [4:0]       mlen;
		logic             valid;
		logic [4:0]       dtm;
		logic [8:0]       dty;
		logic [SUM_W-1:0] wsum;
	} cal_t;

	function automatic logic [4:0] month_days(input logic [3:0] m);
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_days = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: month_days = 5'd30;
			4'd2: month_days = 5'd28;
			default: month_days = 5'd0;
		endcase
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] m);
		case (m)
			4'd1: days_before = 9'd0;
			4'd2: days_before = 9'd31;
			4'd3: days_before = 9'd59;
			4'd4: days_before = 9'd90;
			4'd5: days_before = 9'd120;
			4'd6: days_before = 9'd151;
			4'd7: days_before = 9'd181;
			4'd8: days_before = 9'd212;
			4'd9: days_before = 9'd243;
			4'd10: days_before = 9'd273;
			4'd11: days_before = 9'd304;
			4'd12: days_before = 9'd334;
			default: days_before = 9'd0;
		endcase
	endfunction

	// Floor of 31 * mm / 12 for the shifted month.
	function automatic logic [5:0] month_term(input logic [3:0] mm);
		case (mm)
			4'd0: month_term = 6'd0;
			4'd1: month_term = 6'd2;
			4'd2: month_term = 6'd5;
			4'd3: month_term = 6'd7;
			4'd4: month_term = 6'd10;
			4'd5: month_term = 6'd12;
			4'd6: month_term = 6'd15;
			4'd7: month_term = 6'd18;
			4'd8: month_term = 6'd20;
			4'd9: month_term = 6'd23;
			4'd10: month_term = 6'd25;
			4'd11: month_term = 6'd28;
			4'd12: month_term = 6'd31;
			4'd13: month_term = 6'd33;
			4'd14: month_term = 6'd36;
			4'd15: month_term = 6'd38;
			default: month_term = 6'd0;
		endcase
	endfunction

endpackage

[rtl/core/calendar_date_query.sv]
// Top level of the Gregorian date query pipeline.
// Depends on cdq_pkg, cdq_divide, cdq_calendar, cdq_weekday and assert_macros.svh.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------
//  query    | start, busy        | query  (year, month, day)
//  result   | done (one cycle)   | result (weekday, counts, flags)
//
// One date is taken in every cycle; busy stays low since the pipeline never stops.
// Each result leaves once its query has passed through the five register stages.
// The division of the year by one hundred takes one stage and the reduction modulo seven two.
// Reset clears only the valid bits; there is no stall on either side.
`include "assert_macros.svh"

module calendar_date_query (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cdq_pkg::query_t  query,
	output logic             done,
	output cdq_pkg::result_t result
);
	import cdq_pkg::*;

	logic div_valid;
	div_t div;
	logic cal_valid;
	cal_t cal;

	assign busy = 1'b0;

	cdq_divide u_divide (
		.clk         (clk),
		.arst_n      (arst_n),
		.query_valid (start && !busy),
		.query       (query),
		.div_valid   (div_valid),
		.div         (div)
	);

	cdq_calendar u_calendar (
		.clk       (clk),
		.arst_n    (arst_n),
		.div_valid (div_valid),
		.div       (div),
		.cal_valid (cal_valid),
		.cal       (cal)
	);

	cdq_weekday u_weekday (
		.clk       (clk),
		.arst_n    (arst_n),
		.cal_valid (cal_valid),
		.cal       (cal),
		.done      (done),
		.result    (result)
	);

	`ASSERT_LATER(a_latency, clk, arst_n, start && !busy, ##4 done)
	`ASSERT_IMPLIES(a_invalid_zero, clk, arst_n, done && !result.date_valid,
		(result.weekday == 3'd0) && (result.days_to_year_end == 9'd0)
		&& (result.days_to_month_end == 5'd0) && !result.business_day)
	`ASSERT_IMPLIES(a_valid_counts, clk, arst_n, done && result.date_valid,
		(result.days_to_month_end != 5'd0)
		&& (result.days_to_month_end <= result.month_length)
		&& (result.weekday <= 3'd6)
		&& (result.business_day == !result.weekend))
	`ASSERT_IMPLIES(a_weekend_flag, clk, arst_n, done && result.date_valid,
		result.weekend == ((result.weekday == 3'd0) || (result.weekday == 3'd6)))

endmodule

[rtl/core/cdq_divide.sv]
// Input register and reciprocal division by one hundred of the year.
// Depends on cdq_pkg.
module cdq_divide (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            query_valid,
	input  cdq_pkg::query_t query,
	output logic            div_valid,
	output cdq_pkg::div_t   div
);
	import cdq_pkg::*;

	logic   v_s1;
	query_t q_s1;
	logic   v_s2;
	div_t   d_s2;

	logic               shift_a;
	logic [SHIFT_W-1:0] yy;
	logic [3:0]         mm;
	logic [29:0]        prod_y;
	logic [29:0]        prod_yy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= query_valid;
			v_s2 <= v_s1;
		end
	end

	always_comb begin
		shift_a = (q_s1.month <= 4'd2);
		yy      = SHIFT_W'(q_s1.year) + YEAR_OFFSET - SHIFT_W'(shift_a);
		mm      = shift_a ? (q_s1.month + 4'd10) : (q_s1.month - 4'd2);
		prod_y  = 30'(q_s1.year) * 30'(DIV100_MUL);
		prod_yy = 30'(yy) * 30'(DIV100_MUL);
	end

	always_ff @(posedge clk) begin
		q_s1       <= query;
		d_s2.year  <= q_s1.year;
		d_s2.month <= q_s1.month;
		d_s2.day   <= q_s1.day;
		d_s2.yy    <= yy;
		d_s2.mm    <= mm;
		d_s2.qy    <= prod_y[DIV100_SHIFT +: QUO_W];
		d_s2.qyy   <= prod_yy[DIV100_SHIFT +: QUO_W];
	end

	assign div_valid = v_s2;
	assign div       = d_s2;

endmodule

[rtl/core/cdq_calendar.sv]
// Leap rule, month length, validity, day counts and the weekday sum.
// Depends on cdq_pkg.
module cdq_calendar (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          div_valid,
	input  cdq_pkg::div_t div,
	output logic          cal_valid,
	output cdq_pkg::cal_t cal
);
	import cdq_pkg::*;

	logic v_s3;
	cal_t c_s3;

	logic [YEAR_W-1:0] rem100;
	logic              leap;
	logic              month_ok;
	logic [4:0]        mlen;
	logic              valid;
	logic [8:0]        doy;
	logic [8:0]        ylen;
	logic [SUM_W-1:0]  wsum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= div_valid;
		end
	end

	always_comb begin
		rem100   = div.year - YEAR_W'(div.qy) * YEAR_W'(100);
		leap     = ((div.year[1:0] == 2'd0) && (rem100 != '0))
			|| ((rem100 == '0) && (div.qy[1:0] == 2'd0));
		month_ok = div.month inside {[4'd1:4'd12]};
		mlen     = (div.month == 4'd2) ? (leap ? 5'd29 : 5'd28) : month_days(div.month);
		if (!month_ok) begin
			mlen = 5'd0;
		end
		valid = month_ok && (div.day != 5'd0) && (div.day <= mlen);
		doy   = days_before(div.month) + 9'(div.day) + 9'(leap && (div.month > 4'd2));
		ylen  = leap ? 9'd366 : 9'd365;
		wsum  = SUM_W'(div.day) + div.yy + SUM_W'(div.yy[SHIFT_W-1:2])
			- SUM_W'(div.qyy) + SUM_W'(div.qyy[QUO_W-1:2]) + SUM_W'(month_term(div.mm));
	end

	always_ff @(posedge clk) begin
		c_s3.leap  <= leap;
		c_s3.mlen  <= mlen;
		c_s3.valid <= valid;
		c_s3.dtm   <= valid ? (mlen - div.day + 5'd1) : 5'd0;
		c_s3.dty   <= valid ? (ylen - doy + 9'd1) : 9'd0;
		c_s3.wsum  <= wsum;
	end

	assign cal_valid = v_s3;
	assign cal       = c_s3;

endmodule

[rtl/core/cdq_weekday.sv]
// Reduction of the weekday sum modulo seven and the result register.
// Depends on cdq_pkg.
module cdq_weekday (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cal_valid,
	input  cdq_pkg::cal_t    cal,
	output logic             done,
	output cdq_pkg::result_t result
);
	import cdq_pkg::*;

	logic          v_s4;
	cal_t          c_s4;
	logic [Q7_W-1:0] q7_s4;
	logic          v_s5;
	result_t       r_s5;

	logic [29:0]      prod7;
	logic [SUM_W-1:0] rem7;
	logic [2:0]       wd;
	logic             wknd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s4 <= cal_valid;
			v_s5 <= v_s4;
		end
	end

	always_comb begin
		prod7 = 30'(cal.wsum) * 30'(DIV7_MUL);
		rem7  = c_s4.wsum - SUM_W'(q7_s4) * SUM_W'(7);
		wd    = c_s4.valid ? rem7[2:0] : 3'd0;
		wknd  = c_s4.valid && ((wd == 3'd6) || (wd == 3'd0));
	end

	always_ff @(posedge clk) begin
		c_s4                   <= cal;
		q7_s4                  <= prod7[DIV7_SHIFT +: Q7_W];
		r_s5.weekday           <= wd;
		r_s5.leap_year         <= c_s4.leap;
		r_s5.month_length      <= c_s4.mlen;
		r_s5.end_of_week       <= c_s4.valid && (wd == 3'd6);
		r_s5.weekend           <= wknd;
		r_s5.business_day      <= c_s4.valid && !wknd;
		r_s5.days_to_week_end  <= c_s4.valid ? (3'd6 - wd) : 3'd0;
		r_s5.days_to_month_end <= c_s4.dtm;
		r_s5.days_to_year_end  <= c_s4.dty;
		r_s5.date_valid        <= c_s4.valid;
	end

	assign done   = v_s5;
	assign result = r_s5;

endmodule

[test/calendar_date_query_checker.sv]
// Checker for the date query block: predicts the result of every accepted query and
// compares each result transfer with the oldest prediction. Depends on cdq_pkg.
module calendar_date_query_checker
	import cdq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  query_t  query,
	input  logic    done,
	input  result_t result,
	output int      mismatches,
	output int      outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	result_t expected_answers[$];

	function automatic result_t predict_date(input query_t q);
		int unsigned lens[12];
		int unsigned y, m, d, len, doy, a, yy, mm, s, wd, i;
		bit leap;
		result_t r;
		lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		r = '0;
		y = 32'(q.year);
		m = 32'(q.month);
		d = 32'(q.day);
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		r.leap_year = leap;
		len = 0;
		if (m >= 1 && m <= 12) begin
			len = (m == 2) ? (leap ? 29 : 28) : lens[m - 1];
		end
		r.month_length = 5'(len);
		if (m >= 1 && m <= 12 && d >= 1 && d <= len) begin
			doy = d;
			for (i = 1; i < m; i++) begin
				doy += (i == 2) ? (leap ? 29 : 28) : lens[i - 1];
			end
			// January and February count as the last months of the previous year.
			a = (m <= 2) ? 1 : 0;
			yy = y + 400 - a;
			mm = m + 12 * a - 2;
			s = d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12;
			wd = s % 7;
			r.weekday = 3'(wd);
			r.end_of_week = (wd == 6);
			r.weekend = (wd == 6) || (wd == 0);
			r.business_day = !((wd == 6) || (wd == 0));
			r.days_to_week_end = 3'(6 - wd);
			r.days_to_month_end = 5'(len - d + 1);
			r.days_to_year_end = 9'((leap ? 366 : 365) - doy + 1);
			r.date_valid = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		logic differs;
		if (!arst_n) begin
			expected_answers.delete();
			outstanding = 0;
		end else begin
			if (start && !busy) begin
				expected_answers.push_back(predict_date(query));
			end
			if (done) begin
				if (expected_answers.size() == 0) begin
					if (mismatches < 10) begin
						$display("%0t: result with no query outstanding: %p", $realtime, result);
					end
					mismatches++;
				end else begin
					want = expected_answers.pop_front();
					differs = (result.weekday !== want.weekday)
						|| (result.leap_year !== want.leap_year)
						|| (result.month_length !== want.month_length)
						|| (result.end_of_week !== want.end_of_week)
						|| (result.weekend !== want.weekend)
						|| (result.business_day !== want.business_day)
						|| (result.days_to_week_end !== want.days_to_week_end)
						|| (result.days_to_month_end !== want.days_to_month_end)
						|| (result.days_to_year_end !== want.days_to_year_end)
						|| (result.date_valid !== want.date_valid);
					if (differs) begin
						if (mismatches < 10) begin
							$display("%0t: result mismatch\n  expected %p\n  actual   %p",
								$realtime, want, result);
						end
						mismatches++;
					end
				end
			end
			outstanding = expected_answers.size();
		end
	end

endmodule

[test/calendar_date_query_tb.sv]
// Top of the date query testbench: clock, reset, directed and random queries with
// sender gaps, and the verdict. Depends on cdq_pkg, the block and its checker.
module calendar_date_query_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cdq_pkg::*;

	localparam int CYCLE_LIMIT  = 60000;
	localparam int DRAIN_CYCLES = 10;
	localparam int PHASE_ITEMS  = 410;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	query_t  query = '0;
	logic    done;
	result_t result;
	logic    took = 1'b0;
	int      mismatches;
	int      outstanding;
	int      cycle_count = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	calendar_date_query i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.query  (query),
		.done   (done),
		.result (result)
	);

	calendar_date_query_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.query       (query),
		.done        (done),
		.result      (result),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		took <= start && !busy;
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_date(input int unsigned y, input int unsigned m, input int unsigned d);
		query_t q;
		q.year = 14'(y);
		q.month = 4'(m);
		q.day = 5'(d);
		start <= 1'b1;
		query <= q;
		do @(negedge clk); while (!took);
	endtask

	task automatic wait_results;
		start <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	initial begin
		int phase, n, idle_pct;
		int unsigned y, m, d;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_date(1, 1, 1);
		send_date(9999, 12, 31);
		send_date(0, 2, 29);
		send_date(16383, 15, 31);
		send_date(1900, 2, 29);
		send_date(1900, 2, 28);
		send_date(2000, 2, 29);
		send_date(2024, 2, 29);
		send_date(2023, 2, 29);
		send_date(2024, 1, 1);
		send_date(2024, 12, 31);
		send_date(2023, 12, 31);
		send_date(2023, 1, 1);
		send_date(2024, 3, 1);
		send_date(2024, 4, 30);
		send_date(2024, 4, 31);
		send_date(2024, 6, 0);
		send_date(2024, 0, 15);
		send_date(2024, 13, 1);
		send_date(2024, 8, 31);
		send_date(2024, 6, 1);
		send_date(2024, 6, 2);
		send_date(2024, 6, 3);
		send_date(10000, 3, 14);

		for (phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 23 : (phase == 1) ? 47 : 0;
			if (phase == 2) begin
				wait_results();
				@(negedge clk);
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(99) < 80) begin
					if ($urandom_range(9) == 0) begin
						y = $urandom_range(16383);
					end else if ($urandom_range(4) == 0) begin
						y = 100 * $urandom_range(99);
					end else begin
						y = $urandom_range(9999, 1);
					end
					m = $urandom_range(12, 1);
					d = ($urandom_range(3) == 0) ? $urandom_range(31, 28) : $urandom_range(28, 1);
				end else begin
					y = $urandom_range(16383);
					m = $urandom_range(15);
					d = $urandom_range(31);
				end
				send_date(y, m, d);
				while ($urandom_range(99) < idle_pct) begin
					start <= 1'b0;
					@(negedge clk);
				end
			end
		end

		wait_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
